### design/lwq_pkg.sv
// lwq_pkg: shared types, codes and constants for the lru worker queue
// holds the entry and chain link structs and the cell control struct
// no dependencies
`default_nettype none

package lwq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int ID_W          = 16;
  localparam int STAMP_W       = 32;
  localparam int EXPIRY_W      = 16;
  localparam int FUNC_W        = 2;
  localparam int STATUS_W      = 2;

  localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = EXPIRY_W'(15 * 1000);

  // transaction function codes
  localparam logic [FUNC_W-1:0] FN_TICK    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_READY   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REQUEST = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;

  // cell operations
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_MARK   = 2'd1;
  localparam logic [1:0] OP_SHIFT  = 2'd2;
  localparam logic [1:0] OP_INSERT = 2'd3;

  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // ripple signals passed from the older cell to the newer one
  typedef struct packed {
    logic gap;    // some cell at or before this point is empty
    logic need;   // a valid cell sits behind a hole
    logic valid;  // the previous cell holds an entry
  } link_t;

  typedef struct packed {
    logic [1:0]          op;
    logic                kill_match;
    logic                kill_age;
    logic                kill_head;
    logic [ID_W-1:0]     key;
    logic [STAMP_W-1:0]  now;
    logic [EXPIRY_W-1:0] expiry;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### design/lru_worker_queue_with_expiry.sv
// lru_worker_queue_with_expiry: least recently used worker queue with tick expiry
// top level with sequencer, expiry register, output register and the cell chain
// depends on lwq_pkg and lwq_cell
//
//   channel | signals                                        | direction
//   in      | in_valid in_ready in_func in_worker_id         | transaction in
//   out     | out_valid out_ready out_granted_id out_status  | transaction out
//           | out_occupancy                                  |
//   cfg     | cfg_valid cfg_ready cfg_data (expiry_ticks)    | register write
//
// a transaction passes through the mark, compaction and done states; compaction
// repeats while holes remain, and the left shift through the cell chain
// closes one hole per cycle.
// rst_n is synchronous: the chain empties, time returns to zero, expiry to 15000.
// a finished result waits in the output register while the next transaction is
// taken; the sequencer holds in S_DONE while that register is full and out_ready low.
`default_nettype none

module lru_worker_queue_with_expiry #(
  parameter int QUEUE_DEPTH = lwq_pkg::DEPTH_DEFAULT,
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [lwq_pkg::FUNC_W-1:0]     in_func,
  input  wire  [lwq_pkg::ID_W-1:0]       in_worker_id,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [lwq_pkg::ID_W-1:0]       out_granted_id,
  output logic [lwq_pkg::STATUS_W-1:0]   out_status,
  output logic [CNT_W-1:0]               out_occupancy,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [lwq_pkg::EXPIRY_W-1:0]   cfg_data
);
  import lwq_pkg::*;

  // sequencer states
  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_MARK    = 2'd1;
  localparam logic [1:0] S_COMPACT = 2'd2;
  localparam logic [1:0] S_DONE    = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [FUNC_W-1:0]   func_r;
  logic [ID_W-1:0]     key_r;
  logic [STAMP_W-1:0]  now_r;
  logic [EXPIRY_W-1:0] expiry_r;
  logic [ID_W-1:0]     granted_r;
  logic [STATUS_W-1:0] status_r;

  logic                out_valid_r;
  logic [ID_W-1:0]     out_gid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [CNT_W-1:0]    out_occ_r;

  cell_ctrl_t          ctrl;
  entry_t              ent  [QUEUE_DEPTH];
  link_t               lnk  [QUEUE_DEPTH+1];
  logic [QUEUE_DEPTH-1:0] match_vec;
  logic [QUEUE_DEPTH-1:0] free_vec;

  logic                in_fire;
  logic                found;
  logic                full;
  logic                empty;
  logic                need;
  logic                out_load;
  logic [CNT_W-1:0]    occ;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign found = |match_vec;
  assign full  = ent[QUEUE_DEPTH-1].valid;
  assign empty = !ent[0].valid;
  assign need  = lnk[QUEUE_DEPTH].need;

  // oldest cell sees a filled, gap-free past
  assign lnk[0].gap   = 1'b0;
  assign lnk[0].need  = 1'b0;
  assign lnk[0].valid = 1'b1;

  // cell chain, cell 0 holds the least recently ready worker
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t right;
    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid
      assign right = ent[g+1];
    end
    lwq_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .head         (g == 0),
      .link_in      (lnk[g]),
      .right_ent    (right),
      .ent_o        (ent[g]),
      .link_o       (lnk[g+1]),
      .match_o      (match_vec[g]),
      .first_free_o (free_vec[g])
    );
  end

  // occupancy after compaction: index of the first empty cell
  always_comb begin
    occ = '0;
    if (full) begin
      occ = CNT_W'(QUEUE_DEPTH);
    end else begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (free_vec[i]) begin
          occ = occ | CNT_W'(i);
        end
      end
    end
  end

  // cell control per sequencer state
  always_comb begin
    ctrl            = '0;
    ctrl.key        = key_r;
    ctrl.now        = now_r;
    ctrl.expiry     = expiry_r;
    ctrl.op         = OP_HOLD;
    case (state_r)
      S_MARK: begin
        ctrl.op         = OP_MARK;
        ctrl.kill_match = (func_r == FN_READY);
        ctrl.kill_age   = (func_r == FN_TICK);
        // full queue and a new id: drop the oldest; request: hand out the oldest
        ctrl.kill_head  = ((func_r == FN_READY) && !found && full) ||
                          ((func_r == FN_REQUEST) && !empty);
      end
      S_COMPACT: begin
        if (need) begin
          ctrl.op = OP_SHIFT;
        end else if (func_r == FN_READY) begin
          ctrl.op = OP_INSERT;
        end else begin
          ctrl.op = OP_HOLD;
        end
      end
      default: begin
        ctrl.op = OP_HOLD;
      end
    endcase
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        state_nxt = S_COMPACT;
      end
      S_COMPACT: begin
        if (!need) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      expiry_r    <= EXPIRY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire && (in_func == FN_TICK)) begin
        now_r <= now_r + STAMP_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        expiry_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_func;
      key_r  <= in_worker_id;
    end
    if (state_r == S_MARK) begin
      granted_r <= '0;
      status_r  <= ST_OK;
      if ((func_r == FN_READY) && !found && full) begin
        status_r <= ST_DROPPED;
      end else if (func_r == FN_REQUEST) begin
        if (empty) begin
          status_r <= ST_EMPTY;
        end else begin
          granted_r <= ent[0].id;
        end
      end
    end
    if (out_load) begin
      out_gid_r    <= granted_r;
      out_status_r <= status_r;
      out_occ_r    <= occ;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_granted_id = out_gid_r;
  assign out_status     = out_status_r;
  assign out_occupancy  = out_occ_r;

`ifndef SYNTHESIS
  // a result is only taken from a compacted chain
  a_compact_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> !need)
    else $error("chain still has holes when the result is formed");

  // worker ids held in the chain stay unique
  a_unique_ids: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(match_vec) <= 1)
    else $error("worker id held in more than one cell");

  // an empty grant carries no worker id
  a_empty_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |-> (out_granted_id == '0))
    else $error("empty request granted a worker");

  // occupancy never passes the chain length
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occupancy <= CNT_W'(QUEUE_DEPTH)))
    else $error("occupancy exceeds queue depth");
`endif

endmodule

`default_nettype wire

### design/lwq_cell.sv
// lwq_cell: one slot of the worker queue chain
// holds an id and stamp, marks itself for removal, shifts from the newer neighbor
// depends on lwq_pkg
`default_nettype none

module lwq_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  lwq_pkg::cell_ctrl_t ctrl,
  input  wire                 head,
  input  lwq_pkg::link_t      link_in,
  input  lwq_pkg::entry_t     right_ent,
  output lwq_pkg::entry_t     ent_o,
  output lwq_pkg::link_t      link_o,
  output logic                match_o,
  output logic                first_free_o
);
  import lwq_pkg::*;

  logic               valid_r, valid_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic [STAMP_W-1:0] age;
  logic               too_old;
  logic               kill;
  logic               gap_here;

  assign match_o  = valid_r && (id_r == ctrl.key);
  assign age      = ctrl.now - stamp_r;
  assign too_old  = age > STAMP_W'(ctrl.expiry);
  assign kill     = valid_r && ((ctrl.kill_match && match_o) || (ctrl.kill_age && too_old) ||
                                (ctrl.kill_head && head));
  assign gap_here = link_in.gap | !valid_r;

  assign link_o.gap   = gap_here;
  assign link_o.need  = link_in.need | (valid_r & link_in.gap);
  assign link_o.valid = valid_r;
  assign first_free_o = !valid_r && link_in.valid;

  assign ent_o.valid = valid_r;
  assign ent_o.id    = id_r;
  assign ent_o.stamp = stamp_r;

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    stamp_nxt = stamp_r;
    case (ctrl.op)
      OP_MARK: begin
        valid_nxt = valid_r & !kill;
      end
      OP_SHIFT: begin
        if (gap_here) begin
          valid_nxt = right_ent.valid;
          id_nxt    = right_ent.id;
          stamp_nxt = right_ent.stamp;
        end
      end
      OP_INSERT: begin
        if (first_free_o) begin
          valid_nxt = 1'b1;
          id_nxt    = ctrl.key;
          stamp_nxt = ctrl.now;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    stamp_r <= stamp_nxt;
  end

endmodule

`default_nettype wire

### sim/lru_worker_queue_with_expiry_tb.sv
// lru_worker_queue_with_expiry_tb: self-checking bench for the lru worker queue
// mirrors the queue, tick clock and expiry register and checks every result in order
// depends on lwq_pkg and lru_worker_queue_with_expiry
`default_nettype none

module lru_worker_queue_with_expiry_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lwq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

  // func code 3 has no meaning: the block answers ok and changes nothing
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  localparam int PHASE_ITEMS  = 250;   // counted transactions per random phase
  localparam int ID_POOL      = 24;    // more ids than slots, so the queue fills and ids repeat
  localparam int SETTLE_GAP   = 4 + QUEUE_DEPTH + 4;
  localparam int HOLD_AFTER   = 700;   // results seen before the long receiver stall
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;  // cycles with no transaction on any channel

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] stamp;
  } held_worker_t;

  typedef struct packed {
    logic [ID_W-1:0]     granted;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } grant_result_t;

  // mirror of the worker queue: predicts each result and holds the ones still due
  class worker_queue_mirror;
    held_worker_t        held[$];        // oldest first
    logic [STAMP_W-1:0]  now_ticks = '0;
    logic [EXPIRY_W-1:0] expiry    = EXPIRY_RESET;
    grant_result_t       grants_due[$];
    int unsigned         errors    = 0;

    function void set_expiry(logic [EXPIRY_W-1:0] value);
      expiry = value;
    endfunction

    // drop every entry older than the expiry limit, order kept
    function void purge_stale();
      held_worker_t       kept[$];
      logic [STAMP_W-1:0] age;
      foreach (held[k]) begin
        age = now_ticks - held[k].stamp;
        if (age <= STAMP_W'(expiry)) kept.push_back(held[k]);
      end
      held = kept;
    endfunction

    // a ready worker moves to the back; a new id on a full queue evicts the oldest
    function logic [STATUS_W-1:0] mark_ready(logic [ID_W-1:0] wid);
      logic [STATUS_W-1:0] st;
      int                  hit;
      st  = ST_OK;
      hit = -1;
      foreach (held[k]) if (hit < 0 && held[k].id == wid) hit = k;
      if (hit >= 0) begin
        held.delete(hit);
      end else if (held.size() >= QUEUE_DEPTH) begin
        held.delete(0);
        st = ST_DROPPED;
      end
      held.push_back('{id: wid, stamp: now_ticks});
      return st;
    endfunction

    function void note_transaction(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] wid);
      grant_result_t r;
      r = '{granted: '0, status: ST_OK, occupancy: '0};
      case (fn)
        FN_TICK: begin
          now_ticks = now_ticks + 1'b1;
          purge_stale();
        end
        FN_READY: r.status = mark_ready(wid);
        FN_REQUEST: begin
          if (held.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.granted = held[0].id;
            held.delete(0);
          end
        end
        default: ;
      endcase
      r.occupancy = OCC_W'(held.size());
      grants_due.push_back(r);
    endfunction

    function void check_result(grant_result_t got);
      grant_result_t want;
      if (grants_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: granted=%h status=%0d occupancy=%0d",
                   got.granted, got.status, got.occupancy);
        return;
      end
      want = grants_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected granted=%h status=%0d occupancy=%0d, got granted=%h status=%0d occupancy=%0d",
                   want.granted, want.status, want.occupancy,
                   got.granted, got.status, got.occupancy);
      end
    endfunction

    function int unsigned pending();
      return grants_due.size();
    endfunction

    function int unsigned failures();
      return errors + grants_due.size();
    endfunction
  endclass

  // clock, reset and block inputs, known from time zero, and the block's outputs
  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [FUNC_W-1:0]   in_func      = FN_TICK;
  logic [ID_W-1:0]     in_worker_id = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [ID_W-1:0]     out_granted_id;
  logic [STATUS_W-1:0] out_status;
  logic [OCC_W-1:0]    out_occupancy;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [EXPIRY_W-1:0] cfg_data     = '0;

  worker_queue_mirror mirror = new();

  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;
  int unsigned rx_cycle     = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;

  lru_worker_queue_with_expiry #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_worker_id  (in_worker_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_granted_id(out_granted_id),
    .out_status    (out_status),
    .out_occupancy (out_occupancy),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one transaction; called at a falling edge and returns at one, valid left high
  // so back-to-back transactions never drop valid in between
  task automatic offer(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] wid);
    in_valid     <= 1'b1;
    in_func      <= fn;
    in_worker_id <= wid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mirror.note_transaction(fn, wid);
    @(negedge clk);
  endtask

  // register write only with the block drained; the extra gap covers a late compaction
  task automatic write_expiry(input logic [EXPIRY_W-1:0] value);
    while (mirror.pending() != 0) @(negedge clk);
    repeat (SETTLE_GAP) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mirror.set_expiry(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: rotating stall patterns, including a plain always-ready stretch,
  // and one long hold-off so the output register fills and the input stalls
  always @(negedge clk) begin
    rx_cycle++;
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      case ((rx_cycle / 97) % 4)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 1);
        2:       out_ready <= (rx_cycle % 5) != 0;
        default: out_ready <= ($urandom_range(0, 7) >= 6);
      endcase
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      mirror.check_result('{granted: out_granted_id, status: out_status,
                            occupancy: out_occupancy});
      results_seen++;
    end
  end

  // watchdog: a run with no transaction on any channel for too long has hung
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [EXPIRY_W-1:0] phase_expiry [6];
    logic [FUNC_W-1:0]   fn;
    logic [ID_W-1:0]     wid;
    logic [ID_W-1:0]     pool_base;
    int unsigned         done_items;
    int unsigned         burst;
    int unsigned         gap;
    int unsigned         pick;

    // reset held, then released at a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, reset expiry
    offer(FN_REQUEST, 16'h0000);        // request on empty queue
    offer(FN_TICK, 16'h5A5A);
    offer(FN_UNUSED, 16'hFFFF);         // unused code is ignored
    offer(FN_READY, 16'h0000);          // lowest id
    offer(FN_READY, 16'hFFFF);          // highest id
    offer(FN_READY, 16'h0000);          // id already held moves to the back
    offer(FN_REQUEST, 16'h1234);        // hands out the highest id
    for (int k = 1; k < QUEUE_DEPTH; k++)
      offer(FN_READY, ID_W'(16'h1000 + k));  // fill to the brim, equal stamps
    offer(FN_READY, 16'hA5A5);          // new id on a full queue drops the oldest
    offer(FN_READY, 16'h1001);          // held id on a full queue, no drop
    offer(FN_TICK, 16'h0000);
    offer(FN_REQUEST, 16'h0000);
    in_valid <= 1'b0;

    // expiry settings for the random phases, extremes and the reset value among them
    phase_expiry[0] = '0;
    phase_expiry[1] = 16'd1;
    phase_expiry[2] = EXPIRY_W'($urandom_range(2, 12));
    phase_expiry[3] = '1;
    phase_expiry[4] = EXPIRY_W'($urandom_range(13, 300));
    phase_expiry[5] = EXPIRY_RESET;

    for (int ph = 0; ph < 6; ph++) begin
      write_expiry(phase_expiry[ph]);
      pool_base  = ID_W'($urandom_range(0, 65535 - ID_POOL));
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        // mostly short bursts, now and then a long unbroken run
        burst = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
        repeat (burst) begin
          pick = $urandom_range(0, 99);
          if (pick < 20)      fn = FN_TICK;
          else if (pick < 65) fn = FN_READY;
          else if (pick < 95) fn = FN_REQUEST;
          else                fn = FN_UNUSED;
          // ready ids mostly from a small pool so they repeat, some anywhere
          pick = $urandom_range(0, 9);
          if (fn != FN_READY || pick >= 8)
            wid = ID_W'($urandom_range(0, 65535));
          else if (pick == 7)
            wid = ($urandom_range(0, 1) == 1) ? '1 : '0;
          else
            wid = pool_base + ID_W'($urandom_range(0, ID_POOL - 1));
          offer(fn, wid);
          if (fn != FN_UNUSED) done_items++;
        end
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      in_valid <= 1'b0;
      @(negedge clk);
    end

    // drain, then let the block settle
    while (mirror.pending() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);

    if (mirror.failures() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
